>>> design/lss_pkg.sv
package lss_pkg;

    // Slot table size and derived widths
    localparam int SLOTS  = 32;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // Ticket sum never exceeds SLOTS * 65535
    localparam int SUM_W  = 16 + $clog2(SLOTS);

    // Generator
    localparam int          RAND_W    = 32;
    localparam int          DIV_CNT_W = $clog2(RAND_W);
    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_ADD   = 32'd1013904223;
    localparam logic [31:0] RAND_INIT = 32'd1;

    // Input op codes (s_tuser)
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DRAW  = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Classified command
    typedef enum logic [1:0] {
        CMD_WRITE,
        CMD_DRAW,
        CMD_SKIP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [4:0]  slot;
        logic        occupied;
        logic        runnable;
        logic [15:0] tickets;
    } cmd_t;

endpackage

>>> design/lss_front.sv
module lss_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [23:0]   s_tdata,   // slot[4:0], occupied[5], runnable[6], tickets[22:7], zero[23]
    input  logic          s_tuser,   // op
    output lss_pkg::cmd_t q_cmd,
    output logic          q_valid,
    input  logic          q_ready
);
    import lss_pkg::*;

    cmd_t              in_cmd;
    cmd_t              fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    // Unpack and classify the incoming word
    always_comb begin
        in_cmd.slot     = s_tdata[4:0];
        in_cmd.occupied = s_tdata[5];
        in_cmd.runnable = s_tdata[6];
        in_cmd.tickets  = s_tdata[22:7];
        if (s_tuser == OP_DRAW) begin
            in_cmd.kind = CMD_DRAW;
        end else if (int'(s_tdata[4:0]) < SLOTS) begin
            in_cmd.kind = CMD_WRITE;
        end else begin
            in_cmd.kind = CMD_SKIP;    // out-of-range write, answer only
        end
    end

    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_cmd    = fifo_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Queue control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> design/lss_back.sv
module lss_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  lss_pkg::cmd_t q_cmd,
    input  logic          q_valid,
    output logic          q_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,   // winner_slot[4:0], zero[7:5]
    output logic          m_tuser    // found
);
    import lss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_STEP,
        ST_DIV,
        ST_WALK,
        ST_RESULT
    } state_t;

    state_t               state_reg;
    logic [SLOT_W-1:0]    cnt_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     rem_reg;
    logic [RAND_W-1:0]    rand_reg;
    logic [RAND_W-1:0]    quo_reg;
    logic                 found_reg;
    logic [4:0]           winner_reg;
    logic                 m_tvalid_reg;
    logic [4:0]           m_slot_reg;
    logic                 m_found_reg;
    logic [SLOTS-1:0]     occ_reg;
    logic [SLOTS-1:0]     run_reg;
    logic [15:0]          tickets_reg [SLOTS];

    logic                 elig;
    logic [SUM_W-1:0]     tk;
    logic [SUM_W-1:0]     sum_add;
    logic                 last_slot;
    logic [RAND_W-1:0]    rand_step;
    logic [SUM_W:0]       rem_shift;
    logic [SUM_W:0]       rem_sub;
    logic [SUM_W-1:0]     rem_new;
    logic                 hit;
    logic                 out_free;
    logic                 tbl_write;

    // Current slot under the scan counter
    assign elig      = occ_reg[cnt_reg] & run_reg[cnt_reg];
    assign tk        = SUM_W'(tickets_reg[cnt_reg]);
    assign sum_add   = sum_reg + (elig ? tk : '0);
    assign last_slot = (cnt_reg == SLOT_W'(SLOTS - 1));

    // LCG step, mod 2^32
    assign rand_step = rand_reg * LCG_MUL + LCG_ADD;

    // Restoring remainder, one dividend bit per cycle
    assign rem_shift = {rem_reg, quo_reg[RAND_W-1]};
    assign rem_sub   = rem_shift - {1'b0, sum_reg};
    assign rem_new   = (rem_shift >= {1'b0, sum_reg}) ? SUM_W'(rem_sub) : SUM_W'(rem_shift);

    // Walk: this slot wins when the remaining draw falls inside its tickets
    assign hit       = elig && (rem_reg < tk);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign q_ready   = (state_reg == ST_IDLE);
    assign tbl_write = (state_reg == ST_IDLE) && q_valid && (q_cmd.kind == CMD_WRITE);

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {3'b000, m_slot_reg};
    assign m_tuser   = m_found_reg;

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            div_cnt_reg  <= '0;
            rand_reg     <= RAND_INIT;
            occ_reg      <= '0;
            run_reg      <= '0;
            found_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // Drop valid once taken; a result loading this cycle sets it instead
            if (m_tvalid_reg && m_tready && (state_reg != ST_RESULT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        found_reg  <= 1'b0;
                        winner_reg <= '0;
                        cnt_reg    <= '0;
                        sum_reg    <= '0;
                        case (q_cmd.kind)
                            CMD_WRITE: begin
                                occ_reg[SLOT_W'(q_cmd.slot)] <= q_cmd.occupied;
                                run_reg[SLOT_W'(q_cmd.slot)] <= q_cmd.runnable;
                                state_reg <= ST_RESULT;
                            end
                            CMD_DRAW: begin
                                state_reg <= ST_SUM;
                            end
                            default: begin
                                state_reg <= ST_RESULT;
                            end
                        endcase
                    end
                end
                ST_SUM: begin
                    sum_reg <= sum_add;
                    if (last_slot) begin
                        cnt_reg   <= '0;
                        // empty pool: no draw, generator untouched
                        state_reg <= (sum_add == '0) ? ST_RESULT : ST_STEP;
                    end else begin
                        cnt_reg <= cnt_reg + SLOT_W'(1);
                    end
                end
                ST_STEP: begin
                    rand_reg    <= rand_step;
                    quo_reg     <= rand_step;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                    state_reg   <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg     <= rem_new;
                    quo_reg     <= {quo_reg[RAND_W-2:0], 1'b0};
                    div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
                    if (div_cnt_reg == '1) begin
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (hit) begin
                        found_reg  <= 1'b1;
                        winner_reg <= 5'(cnt_reg);
                        state_reg  <= ST_RESULT;
                    end else begin
                        if (elig) begin
                            rem_reg <= rem_reg - tk;
                        end
                        cnt_reg <= cnt_reg + SLOT_W'(1);
                        if (last_slot) begin
                            state_reg <= ST_RESULT;
                        end
                    end
                end
                ST_RESULT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_slot_reg   <= winner_reg;
                        m_found_reg  <= found_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Ticket counts; only read for slots marked occupied and runnable
    always_ff @(posedge aclk) begin
        if (tbl_write) begin
            tickets_reg[SLOT_W'(q_cmd.slot)] <= q_cmd.tickets;
        end
    end

endmodule

>>> design/lottery_slot_scheduler_core.sv
// Lottery scheduler over a table of 32 slots.
// Input stream (s_): one word per command. s_tuser is the op: 0 writes a slot
// (occupied, runnable, tickets), 1 draws a winner among occupied runnable slots.
// Result stream (m_): exactly one word per command, in order. m_tdata carries
// the winning slot, m_tuser is found; writes and empty pools give found = 0.
// A two-entry command queue sits between input decode and the execution
// sequencer, so up to two commands are taken while the sequencer is busy.
// A write passes from the idle state straight to the result state. A draw
// sums the tickets of the occupied runnable slots, steps the generator, takes
// the remainder of the draw by the sum (one bit a cycle) and walks the slots
// to the winner; an empty pool ends after the sum. Commands run one at a time
// through the sequencer, so throughput is set by the draw sequence.
// Reset (aresetn low, synchronous) clears all slot marks, empties the queue
// and sets the generator to 1. When m_tready is low the result holds in the
// output register; the sequencer waits, then the queue fills and s_tready drops.
module lottery_slot_scheduler_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // slot[4:0], occupied[5], runnable[6], tickets[22:7], zero[23]
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // winner_slot[4:0], zero[7:5]
    output logic        m_tuser    // found
);
    import lss_pkg::*;

    cmd_t q_cmd;
    logic q_valid;
    logic q_ready;

    // Decode and command queue
    lss_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_cmd    (q_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready)
    );

    // Slot table, draw sequencer and result register
    lss_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_cmd    (q_cmd),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
